>>> src/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Types, constants and the divider step shared by the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned HUE_W    = 15;
  localparam int unsigned SAT_W    = 17;
  // quotient widths: hue fraction is at most 3840, saturation at most 65536
  localparam int unsigned HQ_W     = 12;
  localparam int unsigned SQ_W     = 17;
  localparam int unsigned DIV_STEPS = SQ_W;

  localparam logic [15:0] HUE_SEXTANT2 = 16'd7680;
  localparam logic [15:0] HUE_SEXTANT4 = 16'd15360;
  localparam logic [15:0] HUE_FULL     = 16'd23040;

  // which channel is the largest
  typedef enum logic [1:0] {
    SX_RED,
    SX_GREEN,
    SX_BLUE
  } sext_t;

  // extrema stage payload
  typedef struct packed {
    logic [CHAN_W-1:0] cmax;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] mag;
    logic              neg;
    sext_t             sext;
    logic              gray;
  } ext_t;

  // divider stage payload: two restoring dividers run side by side
  typedef struct packed {
    logic [CHAN_W-1:0] hrem;
    logic [HQ_W-1:0]   hlo;
    logic [HQ_W-1:0]   hq;
    logic [CHAN_W-1:0] srem;
    logic [SQ_W-1:0]   slo;
    logic [SQ_W-1:0]   sq;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] cmax;
    logic              neg;
    sext_t             sext;
    logic              gray;
  } div_t;

  // Hue numerator is 3840*mag = (15*mag) << 8; quotient fits 12 bits, so the
  // partial remainder starts at numerator >> 12. Saturation numerator is
  // delta << 16 with a 17-bit quotient, so it starts at delta >> 1.
  function automatic div_t div_init(input ext_t e);
    div_t        d;
    logic [11:0] m15;
    m15     = {e.mag, 4'b0000} - {4'b0000, e.mag};
    d.hrem  = m15[11:4];
    d.hlo   = {m15[3:0], 8'h00};
    d.hq    = '0;
    d.srem  = {1'b0, e.delta[7:1]};
    d.slo   = {e.delta[0], 16'h0000};
    d.sq    = '0;
    d.delta = e.delta;
    d.cmax  = e.cmax;
    d.neg   = e.neg;
    d.sext  = e.sext;
    d.gray  = e.gray;
    return d;
  endfunction

  // one quotient bit of each divider; the hue divider runs only while hue_en
  function automatic div_t div_step(input div_t s, input logic hue_en);
    div_t       t;
    logic [8:0] sr2;
    logic [8:0] hr2;
    t     = s;
    sr2   = {s.srem, s.slo[SQ_W-1]};
    t.slo = {s.slo[SQ_W-2:0], 1'b0};
    if (sr2 >= {1'b0, s.cmax}) begin
      t.srem = 8'(sr2 - {1'b0, s.cmax});
      t.sq   = {s.sq[SQ_W-2:0], 1'b1};
    end else begin
      t.srem = sr2[7:0];
      t.sq   = {s.sq[SQ_W-2:0], 1'b0};
    end
    hr2 = {s.hrem, s.hlo[HQ_W-1]};
    if (hue_en) begin
      t.hlo = {s.hlo[HQ_W-2:0], 1'b0};
      if (hr2 >= {1'b0, s.delta}) begin
        t.hrem = 8'(hr2 - {1'b0, s.delta});
        t.hq   = {s.hq[HQ_W-2:0], 1'b1};
      end else begin
        t.hrem = hr2[7:0];
        t.hq   = {s.hq[HQ_W-2:0], 1'b0};
      end
    end
    return t;
  endfunction

endpackage

>>> src/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pixel pipeline: extrema, 17 restoring divider stages, hue/saturation finish.
// ----------------------------------------------------------------------------
// Stages: 1 extrema stage, 17 divider stages set by the 17-bit saturation
//   quotient, 1 output stage.
// Throughput: one item per cycle unless out_ready stalls the output; stalls collapse bubbles stage by stage.
// Reset: synchronous active-low rst_n clears all valid bits; payload is
//   not reset.
module rgb_to_hsv_converter
  import rhsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HUE_W-1:0]  out_hue,
  output logic [SAT_W-1:0]  out_saturation,
  output logic [CHAN_W-1:0] out_brightness
);

  // ---------------- stage ready chain ----------------
  logic                 ext_v_r;
  ext_t                 ext_r;
  ext_t                 ext_nxt;
  logic [DIV_STEPS-1:0] div_v_r;
  div_t                 div_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] div_rdy;
  logic                 ext_rdy;
  logic                 out_rdy;
  logic                 out_valid_r;
  logic [HUE_W-1:0]     out_hue_r;
  logic [HUE_W-1:0]     out_hue_nxt;
  logic [SAT_W-1:0]     out_sat_r;
  logic [SAT_W-1:0]     out_sat_nxt;
  logic [CHAN_W-1:0]    out_bri_r;

  assign out_rdy = !out_valid_r || out_ready;

  always_comb begin
    div_rdy[DIV_STEPS-1] = !div_v_r[DIV_STEPS-1] || out_rdy;
    for (int k = DIV_STEPS - 2; k >= 0; k--) begin
      div_rdy[k] = !div_v_r[k] || div_rdy[k+1];
    end
  end

  assign ext_rdy  = !ext_v_r || div_rdy[0];
  assign in_ready = ext_rdy;

  // ---------------- extrema stage ----------------
  always_comb begin
    logic [CHAN_W-1:0] cmin;
    logic [8:0]        diff;
    ext_nxt.cmax = in_red;
    cmin         = in_red;
    if (in_green > ext_nxt.cmax) ext_nxt.cmax = in_green;
    if (in_blue > ext_nxt.cmax)  ext_nxt.cmax = in_blue;
    if (in_green < cmin)         cmin = in_green;
    if (in_blue < cmin)          cmin = in_blue;
    ext_nxt.delta = ext_nxt.cmax - cmin;
    ext_nxt.gray  = (ext_nxt.delta == '0);
    // ties go red, then green, then blue
    if (ext_nxt.cmax == in_red) begin
      ext_nxt.sext = SX_RED;
      diff         = {1'b0, in_green} - {1'b0, in_blue};
    end else if (ext_nxt.cmax == in_green) begin
      ext_nxt.sext = SX_GREEN;
      diff         = {1'b0, in_blue} - {1'b0, in_red};
    end else begin
      ext_nxt.sext = SX_BLUE;
      diff         = {1'b0, in_red} - {1'b0, in_green};
    end
    ext_nxt.neg = diff[8];
    ext_nxt.mag = diff[8] ? 8'(9'd0 - diff) : diff[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_v_r <= 1'b0;
    end else if (ext_rdy) begin
      ext_v_r <= in_valid;
    end
    if (ext_rdy) begin
      ext_r <= ext_nxt;
    end
  end

  // ---------------- divider stages ----------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t       div_nxt;
    logic       prev_v;
    localparam logic HueEn = (k < HQ_W);

    if (k == 0) begin : g_first
      assign div_nxt = div_step(div_init(ext_r), HueEn);
      assign prev_v  = ext_v_r;
    end else begin : g_rest
      assign div_nxt = div_step(div_r[k-1], HueEn);
      assign prev_v  = div_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k] <= 1'b0;
      end else if (div_rdy[k]) begin
        div_v_r[k] <= prev_v;
      end
      if (div_rdy[k]) begin
        div_r[k] <= div_nxt;
      end
    end
  end

  // ---------------- output stage ----------------
  always_comb begin
    div_t        fin;
    logic [15:0] base;
    logic [15:0] hsum;
    fin = div_r[DIV_STEPS-1];
    case (fin.sext)
      SX_RED:   base = '0;
      SX_GREEN: base = HUE_SEXTANT2;
      SX_BLUE:  base = HUE_SEXTANT4;
      default:  base = '0;
    endcase
    if (fin.neg) begin
      hsum = base - {4'b0000, fin.hq};
    end else begin
      hsum = base + {4'b0000, fin.hq};
    end
    // negative hue wraps once around the circle
    if (hsum[15]) begin
      hsum = hsum + HUE_FULL;
    end
    out_hue_nxt = fin.gray ? '0 : hsum[HUE_W-1:0];
    out_sat_nxt = fin.gray ? '0 : fin.sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_v_r[DIV_STEPS-1];
    end
    if (out_rdy) begin
      out_hue_r <= out_hue_nxt;
      out_sat_r <= out_sat_nxt;
      out_bri_r <= div_r[DIV_STEPS-1].cmax;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_brightness = out_bri_r;

  // ---------------- assertions ----------------
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_FULL[HUE_W-1:0]))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturation <= 17'd65536))
    else $error("saturation above one");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_saturation == '0)) |-> (out_hue == '0))
    else $error("zero saturation with nonzero hue");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && ext_v_r && (&div_v_r)))
    else $error("input stalled with a bubble in the pipeline");

endmodule
